// ===== sv/hmq_pkg.sv =====
// package for the indexed min-heap queue unit
// holds item types, operation and status codes and size defaults
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package hmq_pkg;

  localparam int unsigned NAME_BITS      = 10;
  localparam int unsigned NAME_NUM       = 1 << NAME_BITS;
  localparam int unsigned PORT_COST_BITS = 32;
  localparam int unsigned COUNT_BITS     = 11;
  localparam int unsigned CAPACITY_DEF   = 1024;
  localparam int unsigned COST_BITS_DEF  = 32;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_DECREASE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_DEC = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]                operation;
    logic [NAME_BITS-1:0]      entry_name;
    logic [PORT_COST_BITS-1:0] entry_cost;
  } in_item_t;

  typedef struct packed {
    logic [NAME_BITS-1:0]      removed_name;
    logic [PORT_COST_BITS-1:0] removed_cost;
    logic                      was_present;
    logic [COUNT_BITS-1:0]     entry_count;
    status_e                   status;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/hmq_ram.sv =====
// simple dual-port synchronous ram, one write and one read port
// read data registered; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module hmq_ram #(
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/indexed_min_heap_queue_unit.sv =====
// indexed min-heap queue: slot ram holds {name, cost} in heap order,
// position ram maps each name to its 1-based slot (0 = absent)
// an item that is flagged ends without walking the heap; insert/decrease walk up,
// delete walks down with more slot ram reads per level (one read port on the slot ram);
// one item is in work at a time
// after reset a clearing pass zeroes the position ram before items are taken
// depends on hmq_pkg and hmq_ram
`timescale 1ns / 1ps
`default_nettype none

module indexed_min_heap_queue_unit
  import hmq_pkg::*;
#(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned COST_BITS = COST_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int unsigned SLOT_AW  = $clog2(CAPACITY);
  localparam int unsigned POS_BITS = $clog2(CAPACITY + 1);
  localparam int unsigned PW       = POS_BITS + 1;
  localparam int unsigned HW       = NAME_BITS + COST_BITS;

  typedef enum logic [12:0] {
    S_CLR      = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_DISP     = 13'b0000000000100,
    S_DEC_CHK  = 13'b0000000001000,
    S_UP_RD    = 13'b0000000010000,
    S_UP_CMP   = 13'b0000000100000,
    S_DEL_BEST = 13'b0000001000000,
    S_DEL_LAST = 13'b0000010000000,
    S_DN_CHK   = 13'b0000100000000,
    S_DN_L     = 13'b0001000000000,
    S_DN_R     = 13'b0010000000000,
    S_DN_DEC   = 13'b0100000000000,
    S_DN_CLR   = 13'b1000000000000
  } state_e;

  state_e                state_q, state_d;
  logic [POS_BITS-1:0]   size_q, size_d;
  logic [NAME_BITS-1:0]  clr_q, clr_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;
  logic [1:0]            op_q, op_d;
  logic [NAME_BITS-1:0]  nm_q, nm_d;
  logic [COST_BITS-1:0]  cost_q, cost_d;
  logic                  present_q, present_d;
  logic [PW-1:0]         p_q, p_d;
  logic [HW-1:0]         item_q, item_d;
  logic [HW-1:0]         best_q, best_d;
  logic [HW-1:0]         left_q, left_d;
  logic [HW-1:0]         child_q, child_d;

  logic                  h_we, h_re;
  logic [SLOT_AW-1:0]    h_wa, h_ra;
  logic [HW-1:0]         h_wd, h_rd;
  logic                  p_we, p_re;
  logic [NAME_BITS-1:0]  p_wa, p_ra;
  logic [POS_BITS-1:0]   p_wd, p_rd;

  logic                  fin;
  status_e               fin_status;
  logic                  fin_rm;
  logic                  name_ok;
  logic                  in_acc;

  function automatic logic [SLOT_AW-1:0] slot_addr(input logic [PW-1:0] pos);
    logic [PW-1:0] idx;
    idx = pos - PW'(1);
    return idx[SLOT_AW-1:0];
  endfunction

  function automatic logic [COST_BITS-1:0] cost_of(input logic [HW-1:0] e);
    return e[COST_BITS-1:0];
  endfunction

  function automatic logic [NAME_BITS-1:0] name_of(input logic [HW-1:0] e);
    return e[HW-1:COST_BITS];
  endfunction

  hmq_ram #(.AW(SLOT_AW), .DW(HW)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_wa),
    .wdata_i (h_wd),
    .re_i    (h_re),
    .raddr_i (h_ra),
    .rdata_o (h_rd)
  );

  hmq_ram #(.AW(NAME_BITS), .DW(POS_BITS)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_wa),
    .wdata_i (p_wd),
    .re_i    (p_re),
    .raddr_i (p_ra),
    .rdata_o (p_rd)
  );

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign name_ok     = 32'(nm_q) < CAPACITY;

  always_comb begin
    state_d    = state_q;
    size_d     = size_q;
    clr_d      = clr_q;
    op_d       = op_q;
    nm_d       = nm_q;
    cost_d     = cost_q;
    present_d  = present_q;
    p_d        = p_q;
    item_d     = item_q;
    best_d     = best_q;
    left_d     = left_q;
    child_d    = child_q;
    h_we       = 1'b0;
    h_wa       = '0;
    h_wd       = '0;
    h_re       = 1'b0;
    h_ra       = '0;
    p_we       = 1'b0;
    p_wa       = '0;
    p_wd       = '0;
    p_re       = 1'b0;
    p_ra       = '0;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_rm     = 1'b0;

    unique case (state_q)
      S_CLR: begin
        p_we  = 1'b1;
        p_wa  = clr_q;
        clr_d = clr_q + NAME_BITS'(1);
        if (clr_q == NAME_BITS'(NAME_NUM - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_d    = in_item_i.operation;
          nm_d    = in_item_i.entry_name;
          cost_d  = COST_BITS'(in_item_i.entry_cost);
          p_re    = 1'b1;
          p_ra    = in_item_i.entry_name;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        present_d = name_ok && (p_rd != '0);
        case (op_q)
          OP_INSERT: begin
            if (!name_ok || present_d || size_q == POS_BITS'(CAPACITY)) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else begin
              size_d  = size_q + POS_BITS'(1);
              p_d     = PW'(size_q) + PW'(1);
              item_d  = {nm_q, cost_q};
              state_d = S_UP_RD;
            end
          end
          OP_DELETE: begin
            if (size_q == '0) begin
              fin        = 1'b1;
              fin_status = ST_EMPTY;
            end else begin
              h_re    = 1'b1;
              h_ra    = '0;
              state_d = S_DEL_BEST;
            end
          end
          OP_DECREASE: begin
            if (!present_d) begin
              fin        = 1'b1;
              fin_status = ST_BAD_DEC;
            end else begin
              h_re    = 1'b1;
              h_ra    = slot_addr(PW'(p_rd));
              p_d     = PW'(p_rd);
              item_d  = {nm_q, cost_q};
              state_d = S_DEC_CHK;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_DEC_CHK: begin
        if (!(cost_q < cost_of(h_rd))) begin
          fin        = 1'b1;
          fin_status = ST_BAD_DEC;
        end else begin
          state_d = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (p_q == PW'(1)) begin
          h_we = 1'b1;
          h_wa = slot_addr(p_q);
          h_wd = item_q;
          p_we = 1'b1;
          p_wa = name_of(item_q);
          p_wd = POS_BITS'(p_q);
          fin  = 1'b1;
        end else begin
          h_re    = 1'b1;
          h_ra    = slot_addr(p_q >> 1);
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        h_we = 1'b1;
        h_wa = slot_addr(p_q);
        p_we = 1'b1;
        p_wd = POS_BITS'(p_q);
        if (cost_of(h_rd) > cost_of(item_q)) begin
          h_wd    = h_rd;
          p_wa    = name_of(h_rd);
          p_d     = p_q >> 1;
          state_d = S_UP_RD;
        end else begin
          h_wd = item_q;
          p_wa = name_of(item_q);
          fin  = 1'b1;
        end
      end
      S_DEL_BEST: begin
        best_d  = h_rd;
        h_re    = 1'b1;
        h_ra    = slot_addr(PW'(size_q));
        state_d = S_DEL_LAST;
      end
      S_DEL_LAST: begin
        item_d = h_rd;
        size_d = size_q - POS_BITS'(1);
        if (size_q == POS_BITS'(1)) begin
          p_we   = 1'b1;
          p_wa   = name_of(best_q);
          fin    = 1'b1;
          fin_rm = 1'b1;
        end else begin
          p_d     = PW'(2);
          state_d = S_DN_CHK;
        end
      end
      S_DN_CHK: begin
        if (p_q > PW'(size_q)) begin
          h_we    = 1'b1;
          h_wa    = slot_addr(p_q >> 1);
          h_wd    = item_q;
          p_we    = 1'b1;
          p_wa    = name_of(item_q);
          p_wd    = POS_BITS'(p_q >> 1);
          state_d = S_DN_CLR;
        end else begin
          h_re    = 1'b1;
          h_ra    = slot_addr(p_q);
          state_d = S_DN_L;
        end
      end
      S_DN_L: begin
        left_d = h_rd;
        if (p_q + PW'(1) <= PW'(size_q)) begin
          h_re    = 1'b1;
          h_ra    = slot_addr(p_q + PW'(1));
          state_d = S_DN_R;
        end else begin
          child_d = h_rd;
          state_d = S_DN_DEC;
        end
      end
      S_DN_R: begin
        if (cost_of(h_rd) < cost_of(left_q)) begin
          child_d = h_rd;
          p_d     = p_q + PW'(1);
        end else begin
          child_d = left_q;
        end
        state_d = S_DN_DEC;
      end
      S_DN_DEC: begin
        h_we = 1'b1;
        h_wa = slot_addr(p_q >> 1);
        p_we = 1'b1;
        p_wd = POS_BITS'(p_q >> 1);
        if (cost_of(item_q) <= cost_of(child_q)) begin
          h_wd    = item_q;
          p_wa    = name_of(item_q);
          state_d = S_DN_CLR;
        end else begin
          h_wd    = child_q;
          p_wa    = name_of(child_q);
          p_d     = p_q << 1;
          state_d = S_DN_CHK;
        end
      end
      S_DN_CLR: begin
        p_we   = 1'b1;
        p_wa   = name_of(best_q);
        fin    = 1'b1;
        fin_rm = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (fin) begin
      state_d                  = S_IDLE;
      out_valid_d              = 1'b1;
      out_d.removed_name       = fin_rm ? name_of(best_q) : '0;
      out_d.removed_cost       = fin_rm ? PORT_COST_BITS'(cost_of(best_q)) : '0;
      out_d.was_present        = present_d;
      out_d.entry_count        = COUNT_BITS'(size_d);
      out_d.status             = fin_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      size_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    op_q      <= op_d;
    nm_q      <= nm_d;
    cost_q    <= cost_d;
    present_q <= present_d;
    p_q       <= p_d;
    item_q    <= item_d;
    best_q    <= best_d;
    left_q    <= left_d;
    child_q   <= child_d;
  end

  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= POS_BITS'(CAPACITY))
    else $error("entry count above capacity");

  a_size_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q != $past(size_q) |->
      (size_q == $past(size_q) + POS_BITS'(1)) || (size_q + POS_BITS'(1) == $past(size_q)))
    else $error("entry count moved by more than one");

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_DISP)
    else $error("accepted item not dispatched");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> state_q == S_IDLE)
    else $error("result raised while heap walk in progress");

endmodule

`default_nettype wire
